// ----- design/ihb_pkg.sv -----
// Shared types and constants for the IPv4 header builder.
package ihb_pkg;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned LenW   = 16;
  localparam int unsigned WordW  = 16;
  localparam int unsigned ProtoW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [LenW-1:0]  HdrBytes   = 16'd20;
  localparam logic [LenW-1:0]  MaxPayload = 16'd65515;
  localparam logic [LenW-1:0]  MaxTotal   = 16'hffff;
  localparam logic [WordW-1:0] VerIhlDsf  = 16'h4500;
  localparam logic [WordW-1:0] FlagsDf    = 16'h4000;
  localparam logic [7:0]       TtlDefault = 8'd64;
  localparam logic [AddrW-1:0] AddrBcast  = 32'hffff_ffff;
  localparam logic [AddrW-1:0] McastMask  = 32'hf000_0000;
  localparam logic [AddrW-1:0] McastNet   = 32'he000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LOCAL_ADDR = 2'd0,
    CFG_SUBNET     = 2'd1,
    CFG_GATEWAY    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [AddrW-1:0]  dest_address;
    logic [ProtoW-1:0] protocol_number;
    logic [LenW-1:0]   payload_length;
  } req_t;

  typedef struct packed {
    logic [LenW-1:0]  total_length;
    logic [WordW-1:0] identification;
    logic [WordW-1:0] header_checksum;
    logic [AddrW-1:0] next_hop;
    logic             via_gateway;
  } hdr_t;

  // Variable header words that feed the checksum.
  typedef struct packed {
    logic [LenW-1:0]   total_length;
    logic [WordW-1:0]  identification;
    logic [ProtoW-1:0] protocol_number;
    logic [AddrW-1:0]  src_address;
    logic [AddrW-1:0]  dst_address;
  } csum_in_t;

endpackage

// ----- design/ihb_stream_if.sv -----
// Valid/ready channels for requests and finished headers.
interface ihb_req_if import ihb_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ihb_hdr_if import ihb_pkg::*; ();
  logic valid;
  logic ready;
  hdr_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/ihb_csum.sv -----
// Ones-complement header checksum over the ten IPv4 header words.
module ihb_csum import ihb_pkg::*; (
  input  csum_in_t         fields_i,
  output logic [WordW-1:0] checksum_o
);

  localparam int unsigned SumW = WordW + 4;

  logic [SumW-1:0]  sum_raw;
  logic [WordW:0]   fold1;
  logic [WordW-1:0] fold2;

  always_comb begin
    sum_raw = SumW'(VerIhlDsf) + SumW'(FlagsDf)
            + SumW'(fields_i.total_length)
            + SumW'(fields_i.identification)
            + SumW'({TtlDefault, fields_i.protocol_number})
            + SumW'(fields_i.src_address[AddrW-1:WordW])
            + SumW'(fields_i.src_address[WordW-1:0])
            + SumW'(fields_i.dst_address[AddrW-1:WordW])
            + SumW'(fields_i.dst_address[WordW-1:0]);
    // End-around carry; two folds are enough for a 20-bit sum.
    fold1 = (WordW+1)'(sum_raw[WordW-1:0]) + (WordW+1)'(sum_raw[SumW-1:WordW]);
    fold2 = fold1[WordW-1:0] + WordW'(fold1[WordW]);
    checksum_o = ~fold2;
  end

endmodule

// ----- design/ipv4_header_builder.sv -----
// IPv4 header builder: header fields, checksum and next-hop selection.
//
// Requests arrive on req_i (destination, protocol, payload length); one
// header result per request leaves on hdr_o. Both are valid/ready channels,
// a transaction completes when valid and ready are high at a clock edge.
// The config port writes local address, subnet mask and gateway by index
// (cfg_we_i, cfg_idx_i, cfg_wdata_i); indexes above the list are dropped.
// Write config only while no request is in flight.
//
// Two register stages: a request register and a result register, with the
// checksum adder tree and subnet compare between them. A taken request is held
// in the request register, then moved into the result register, which raises
// hdr_o.valid; one request is taken per cycle when hdr_o is not
// stalled. When hdr_o stalls, the request register still fills, so one
// further request is taken before req_i.ready drops.
//
// Reset clears the id counter, the config registers and both valid flags.
// The identification field counts up by one per request, wrapping at 16 bits.
module ipv4_header_builder import ihb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [AddrW-1:0]   cfg_wdata_i,
  ihb_req_if.sink            req_i,
  ihb_hdr_if.source          hdr_o
);

  logic [AddrW-1:0] local_q, mask_q, gw_q;
  logic [WordW-1:0] id_q;
  logic             s1_vld_q, out_vld_q;
  req_t             s1_q;
  hdr_t             out_q, out_d;
  logic             s1_adv;
  csum_in_t         csum_in;
  logic [WordW-1:0] csum;
  logic [LenW-1:0]  total;
  logic             off_net;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      local_q <= '0;
      mask_q  <= '0;
      gw_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LOCAL_ADDR: local_q <= cfg_wdata_i;
        CFG_SUBNET:     mask_q  <= cfg_wdata_i;
        CFG_GATEWAY:    gw_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign s1_adv      = !out_vld_q || hdr_o.ready;
  assign req_i.ready = !s1_vld_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (req_i.ready) begin
      s1_vld_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_q <= req_i.data;
    end
  end

  // Header fields for the request in stage one
  always_comb begin
    total = (s1_q.payload_length > MaxPayload) ? MaxTotal
                                               : s1_q.payload_length + HdrBytes;
    off_net = (mask_q != '0) && (s1_q.dest_address != AddrBcast)
           && ((s1_q.dest_address & McastMask) != McastNet)
           && ((local_q & mask_q) != (s1_q.dest_address & mask_q));

    csum_in.total_length    = total;
    csum_in.identification  = id_q;
    csum_in.protocol_number = s1_q.protocol_number;
    csum_in.src_address     = local_q;
    csum_in.dst_address     = s1_q.dest_address;

    out_d.total_length    = total;
    out_d.identification  = id_q;
    out_d.header_checksum = csum;
    out_d.next_hop        = off_net ? gw_q : s1_q.dest_address;
    out_d.via_gateway     = off_net;
  end

  ihb_csum u_csum (
    .fields_i   (csum_in),
    .checksum_o (csum)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      id_q      <= '0;
    end else if (s1_adv) begin
      out_vld_q <= s1_vld_q;
      if (s1_vld_q) begin
        id_q <= id_q + WordW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_vld_q) begin
      out_q <= out_d;
    end
  end

  assign hdr_o.valid = out_vld_q;
  assign hdr_o.data  = out_q;

  // Each header leaving stage one consumes exactly one identification.
  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && s1_adv |=> id_q == $past(id_q) + WordW'(1))
    else $error("id counter did not step once per header");

  a_id_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_vld_q && s1_adv) |=> id_q == $past(id_q))
    else $error("id counter moved without a header");

  a_gw_hop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.via_gateway |-> out_q.next_hop == gw_q)
    else $error("gateway route without gateway next hop");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && out_vld_q && !hdr_o.ready |-> !req_i.ready)
    else $error("request taken while both stages are full and stalled");

  a_min_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.total_length >= HdrBytes)
    else $error("total length below header size");

endmodule
